/* rtl/core/cooperative_task_scheduler_top_defines.svh */
// Assertion macros for the cooperative task scheduler.
// Included by the top level; each macro expects clk and rst in scope.
`ifndef COOPERATIVE_TASK_SCHEDULER_TOP_DEFINES_SVH
`define COOPERATIVE_TASK_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cts_pkg.sv */
// Shared types and constants of the cooperative task scheduler.
// No dependencies; used by the lane, merge and top-level modules.
package cts_pkg;

  // Action codes carried by an input word.
  localparam logic [1:0] ACT_INIT   = 2'd0;
  localparam logic [1:0] ACT_CREATE = 2'd1;
  localparam logic [1:0] ACT_WAIT   = 2'd2;
  localparam logic [1:0] ACT_EXIT   = 2'd3;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SLOT  = 2'd1,
    ST_NO_READY = 2'd2
  } status_t;

  // Field widths of the words.
  localparam int CELLS_W  = 16;
  localparam int ADDR_W   = 32;
  localparam int READY_W  = 8;
  localparam int OUT_SLOT_W = 3;
  // One stack cell is four bytes, so a size in bytes is cells shifted by two.
  localparam int CELL_SHIFT = 2;

  // Sequencer states.
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LANE   = 7'b0000010,
    S_MERGE  = 7'b0000100,
    S_CRIT   = 7'b0001000,
    S_ALL    = 7'b0010000,
    S_PRED   = 7'b0100000,
    S_EXSCAN = 7'b1000000
  } state_t;

endpackage

/* rtl/core/cooperative_task_scheduler_top.sv */
// Cooperative task scheduler, top level: slot storage, ring walker, lanes.
// Wait/yield and exit walk the ring one link per cycle; a new command is taken only
// once the last one is through, while busy is low.
// Done is high for a single cycle with each result; the receiver cannot stall.
// Synchronous active-high reset clears all slots and the stack pointer to zero.
// Depends on cts_pkg, cts_lanes, cts_merge and the defines header.
`include "cooperative_task_scheduler_top_defines.svh"

module cooperative_task_scheduler_top
  import cts_pkg::*;
#(
  parameter int TASK_SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ADDR_W-1:0]     cfg_data,
  // Command input.
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            action,
  input  logic [CELLS_W-1:0]    stack_cells,
  input  logic                  critical,
  input  logic [READY_W-1:0]    ready_mask,
  // Result.
  output logic                  done,
  output logic [OUT_SLOT_W-1:0] next_task,
  output logic                  switch_context,
  output logic [OUT_SLOT_W-1:0] new_slot,
  output logic [ADDR_W-1:0]     new_stack_top,
  output logic [1:0]            status
);

  localparam int SW = $clog2(TASK_SLOTS);
  localparam int KW = $clog2(TASK_SLOTS + 1);
  localparam logic [KW-1:0] K_LAST = KW'(TASK_SLOTS);

  state_t state;

  // Slot storage.
  logic [SW-1:0]                     link [TASK_SLOTS];
  logic [ADDR_W-1:0]                 top  [TASK_SLOTS];
  logic [TASK_SLOTS-1:0][CELLS_W-1:0] cells;
  logic [TASK_SLOTS-1:0]             used;
  logic [TASK_SLOTS-1:0]             crit;

  // Scheduler state.
  logic [SW-1:0]     cur;
  logic              any_crit;
  logic [ADDR_W-1:0] sp;
  logic [ADDR_W-1:0] init_top;

  // Latched command word.
  logic [1:0]         act_q;
  logic [CELLS_W-1:0] cells_q;
  logic               crit_q;
  logic [READY_W-1:0] mask_q;

  // Walker and lane results.
  logic [SW-1:0]         walk_n;
  logic [KW-1:0]         walk_k;
  logic [SW-1:0]         cur_link;
  logic [TASK_SLOTS-1:0] fit_vec;
  logic [TASK_SLOTS-1:0] lane_fit;
  logic [TASK_SLOTS-1:0] rdy_vec;
  logic [TASK_SLOTS-1:0] crdy_vec;
  logic                  fit_found;
  logic [SW-1:0]         fit_idx;

  // Single read port on the ring links.
  logic [SW-1:0] link_ra;
  logic [SW-1:0] link_rd;
  logic [ADDR_W-1:0] carve;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = ~busy;
  assign link_ra   = (state == S_LANE) ? cur : walk_n;
  assign link_rd   = link[link_ra];
  assign carve     = ADDR_W'({cells_q, {CELL_SHIFT{1'b0}}});

  // One lane per slot.
  cts_lanes #(.SLOTS(TASK_SLOTS)) u_lanes (
    .used     (used),
    .crit     (crit),
    .cells    (cells),
    .cells_in (cells_q),
    .mask     (mask_q),
    .fit      (lane_fit),
    .rdy      (rdy_vec),
    .crdy     (crdy_vec)
  );

  // Pick the lowest fitting slot from the registered lane flags.
  cts_merge #(.WIDTH(TASK_SLOTS)) u_merge (
    .req   (fit_vec),
    .found (fit_found),
    .idx   (fit_idx)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_top <= '0;
    end else if (cfg_valid && cfg_ready) begin
      init_top <= cfg_data;
    end
  end

  // Sequencer, slot storage and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      cur      <= '0;
      any_crit <= 1'b0;
      sp       <= '0;
      used     <= '0;
      crit     <= '0;
      cells    <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        link[i] <= '0;
        top[i]  <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act_q   <= action;
            cells_q <= stack_cells;
            crit_q  <= critical;
            mask_q  <= ready_mask;
            state   <= S_LANE;
          end
        end

        // Lanes settle on the latched word; dispatch by action.
        S_LANE: begin
          fit_vec  <= lane_fit;
          cur_link <= link_rd;
          walk_k   <= '0;
          unique case (act_q)
            ACT_INIT: begin
              cur            <= '0;
              link[0]        <= '0;
              top[0]         <= init_top;
              cells[0]       <= cells_q;
              used[0]        <= 1'b1;
              sp             <= init_top - carve;
              next_task      <= '0;
              switch_context <= 1'b0;
              new_slot       <= '0;
              new_stack_top  <= init_top;
              status         <= ST_OK;
              done           <= 1'b1;
              state          <= S_IDLE;
            end
            ACT_CREATE: begin
              if (crit_q) begin
                any_crit <= 1'b1;
              end
              state <= S_MERGE;
            end
            ACT_WAIT: begin
              walk_n <= link_rd;
              state  <= any_crit ? S_CRIT : S_ALL;
            end
            ACT_EXIT: begin
              walk_n <= cur;
              state  <= S_PRED;
            end
          endcase
        end

        // Create: claim the chosen slot and link it after the current task.
        S_MERGE: begin
          next_task      <= OUT_SLOT_W'(cur);
          switch_context <= 1'b0;
          if (fit_found) begin
            if (cells[fit_idx] == '0) begin
              top[fit_idx]   <= sp;
              cells[fit_idx] <= cells_q;
              sp             <= sp - carve;
              new_stack_top  <= sp;
            end else begin
              new_stack_top <= top[fit_idx];
            end
            used[fit_idx] <= 1'b1;
            crit[fit_idx] <= crit_q;
            // A chosen slot that is also the current one ends up linked to itself.
            for (int i = 0; i < TASK_SLOTS; i++) begin
              if (SW'(i) == cur) begin
                link[i] <= fit_idx;
              end else if (SW'(i) == fit_idx) begin
                link[i] <= cur_link;
              end
            end
            new_slot      <= OUT_SLOT_W'(fit_idx);
            status        <= ST_OK;
          end else begin
            new_slot      <= '0;
            new_stack_top <= '0;
            status        <= ST_NO_SLOT;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end

        // Wait: look for a ready critical task among the other tasks.
        S_CRIT: begin
          if ((walk_k == K_LAST) || (walk_n == cur)) begin
            walk_n <= cur_link;
            walk_k <= '0;
            state  <= S_ALL;
          end else if (crdy_vec[walk_n]) begin
            next_task      <= OUT_SLOT_W'(walk_n);
            switch_context <= 1'b1;
            new_slot       <= '0;
            new_stack_top  <= '0;
            status         <= ST_OK;
            cur            <= walk_n;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            walk_n <= link_rd;
            walk_k <= walk_k + KW'(1);
          end
        end

        // Wait: walk the ring, current task included, to the first ready task.
        S_ALL: begin
          new_slot      <= '0;
          new_stack_top <= '0;
          if (walk_k == K_LAST) begin
            next_task      <= OUT_SLOT_W'(cur);
            switch_context <= 1'b0;
            status         <= ST_NO_READY;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else if (rdy_vec[walk_n]) begin
            next_task      <= OUT_SLOT_W'(walk_n);
            switch_context <= (walk_n != cur);
            status         <= ST_OK;
            cur            <= walk_n;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            walk_n <= link_rd;
            walk_k <= walk_k + KW'(1);
          end
        end

        // Exit: find the predecessor and unlink the current task.
        S_PRED: begin
          if ((walk_k == K_LAST) || (link_rd == cur)) begin
            if (walk_k != K_LAST) begin
              link[walk_n] <= cur_link;
            end
            used[cur] <= 1'b0;
            walk_n    <= cur_link;
            walk_k    <= '0;
            state     <= S_EXSCAN;
          end else begin
            walk_n <= link_rd;
            walk_k <= walk_k + KW'(1);
          end
        end

        // Exit: walk to the next ready task other than the exiting one.
        S_EXSCAN: begin
          new_slot      <= '0;
          new_stack_top <= '0;
          if (walk_k == K_LAST) begin
            next_task      <= OUT_SLOT_W'(cur);
            switch_context <= 1'b0;
            status         <= ST_NO_READY;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else if ((walk_n != cur) && rdy_vec[walk_n]) begin
            next_task      <= OUT_SLOT_W'(walk_n);
            switch_context <= 1'b1;
            status         <= ST_OK;
            cur            <= walk_n;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            walk_n <= link_rd;
            walk_k <= walk_k + KW'(1);
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only shown once the sequencer is back at rest.
  `CTS_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
  // An accepted word always occupies the block in the next cycle.
  `CTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not start")
  // A failed create reports no slot and no stack top.
  `CTS_ASSERT_NOW(a_noslot_clean, done && (status == ST_NO_SLOT),
                  (new_slot == '0) && (new_stack_top == '0), "failed create carries data")
  // A context switch is only requested on success.
  `CTS_ASSERT_NOW(a_switch_ok, done && switch_context, status == ST_OK,
                  "switch requested with error status")

endmodule

/* rtl/core/cts_lanes.sv */
// Per-slot lanes of the scheduler: fit test for create and ready flags.
// Depends on cts_pkg.
module cts_lanes
  import cts_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic [SLOTS-1:0]              used,
  input  logic [SLOTS-1:0]              crit,
  input  logic [SLOTS-1:0][CELLS_W-1:0] cells,
  input  logic [CELLS_W-1:0]            cells_in,
  input  logic [READY_W-1:0]            mask,
  output logic [SLOTS-1:0]              fit,
  output logic [SLOTS-1:0]              rdy,
  output logic [SLOTS-1:0]              crdy
);

  // Each lane looks at its own slot only.
  for (genvar s = 0; s < SLOTS; s++) begin : g_lane
    // A free slot fits when it has no stack yet or its kept stack is big enough.
    assign fit[s] = !used[s] && ((cells[s] == '0) || (cells_in <= cells[s]));

    // Only the slots covered by the mask can ever be ready.
    if (s < READY_W) begin : g_masked
      assign rdy[s] = mask[s];
    end else begin : g_never
      assign rdy[s] = 1'b0;
    end

    assign crdy[s] = crit[s] && rdy[s];
  end

endmodule

/* rtl/core/cts_merge.sv */
// Merging stage of the scheduler lanes: lowest-index priority encoder.
// Depends on cts_pkg for house conventions only.
module cts_merge
  import cts_pkg::*;
#(
  parameter int WIDTH = 8,
  localparam int IW = $clog2(WIDTH)
) (
  input  logic [WIDTH-1:0] req,
  output logic             found,
  output logic [IW-1:0]    idx
);

  // Scan from the top down so the lowest requesting lane wins.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (req[i]) begin
        found = 1'b1;
        idx   = IW'(i);
      end
    end
  end

endmodule
